// ===== hw/rtl/rud_pkg.sv =====
// rud_pkg: field widths, fixed-point constants, register codes and shared
// structs for the radial undistortion block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rud_pkg;

   // field widths
   localparam int PIXEL_BITS  = 12;
   localparam int PIX_FRAC    = 4;
   localparam int CENTRE_BITS = 16;
   localparam int FOCAL_BITS  = 20;
   localparam int COEFF_BITS  = 32;
   localparam int OUT_BITS    = 20;

   // fixed point: Q.28 normalized values, 31-bit magnitudes
   localparam int FRAC_BITS = 28;
   localparam int QBITS     = 31;

   // output saturation bounds
   localparam int OUT_MAX = 524287;
   localparam int OUT_MIN = -524288;

   // stream packing
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 40;
   localparam int RSP_USER_BITS = 1;

   // register port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_CENTRE_X    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_CENTRE_Y    = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_FOCAL_X     = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_FOCAL_Y     = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_COEFF_ONE   = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_COEFF_TWO   = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_COEFF_THREE = 3'd6;

   localparam logic [FOCAL_BITS-1:0] FOCAL_RESET = 20'd16;

   // configuration seen by the datapath
   typedef struct packed {
      logic        [CENTRE_BITS-1:0] centre_x;
      logic        [CENTRE_BITS-1:0] centre_y;
      logic        [FOCAL_BITS-1:0]  focal_x;
      logic        [FOCAL_BITS-1:0]  focal_y;
      logic signed [COEFF_BITS-1:0]  coeff_one;
      logic signed [COEFF_BITS-1:0]  coeff_two;
      logic signed [COEFF_BITS-1:0]  coeff_three;
   } cfg_type;

   // one result beat
   typedef struct packed {
      logic signed [OUT_BITS-1:0] corrected_x;
      logic signed [OUT_BITS-1:0] corrected_y;
      logic                       saturated;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rud_core.sv =====
// rud_core: pipelined datapath, offset, restoring divide, radial polynomial,
// rescale and saturation; every stage moves on a common advance strobe
// depends on rud_pkg
`timescale 1ns / 1ps
`default_nettype none

module rud_core #(
   parameter int COORD_BITS = 12
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    advance,
   input  wire                                    in_valid,
   input  wire [rud_pkg::PIXEL_BITS-1:0]          in_pixel_x,
   input  wire [rud_pkg::PIXEL_BITS-1:0]          in_pixel_y,
   input  rud_pkg::cfg_type                       cfg,
   output logic                                   out_valid,
   output rud_pkg::rsp_type                       out_rsp
);

   localparam int FRAC  = rud_pkg::FRAC_BITS;
   localparam int QB    = rud_pkg::QBITS;
   localparam int REMW  = rud_pkg::FOCAL_BITS;
   localparam int LOWB  = QB - FRAC;
   localparam int USE_BITS = (COORD_BITS < rud_pkg::PIXEL_BITS) ? COORD_BITS
                                                                 : rud_pkg::PIXEL_BITS;
   localparam int SHW   = USE_BITS + rud_pkg::PIX_FRAC;
   localparam int MW    = (SHW > rud_pkg::CENTRE_BITS) ? SHW : rud_pkg::CENTRE_BITS;
   localparam int DW    = MW + 1;
   localparam int CMPW  = REMW + LOWB + MW;
   localparam int P2W   = 2 * QB;
   localparam int SUMW  = P2W + 1;
   localparam int TW    = rud_pkg::COEFF_BITS + QB + 1;
   localparam int FW    = rud_pkg::COEFF_BITS + QB + 1 - FRAC + 2;
   localparam int FLW   = FW / 2;
   localparam int FHW   = FW - FLW;
   localparam int PHW   = DW + FHW;
   localparam int PLW   = DW + FLW + 1;
   localparam int PW    = DW + FW;
   localparam int VW    = PW - FRAC;
   localparam int SW    = VW + 1;
   localparam int NST   = QB + 14;

   localparam logic [QB-1:0] NMAX = {QB{1'b1}};
   localparam logic signed [FW-1:0] FACTOR_ONE =
      {{(FW - FRAC - 1){1'b0}}, 1'b1, {FRAC{1'b0}}};
   localparam logic signed [SW-1:0] SAT_HI = SW'(rud_pkg::OUT_MAX);
   localparam logic signed [SW-1:0] SAT_LO = SW'(rud_pkg::OUT_MIN);

   typedef struct packed {
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic                 clamp_x;
      logic                 clamp_y;
      logic [LOWB-1:0]      lo_x;
      logic [LOWB-1:0]      lo_y;
      logic [REMW-1:0]      rem_x;
      logic [REMW-1:0]      rem_y;
      logic [QB-1:0]        q_x;
      logic [QB-1:0]        q_y;
   } div_type;

   // one restoring step: returns {quotient bit, new remainder}
   function automatic logic [REMW:0] div_step(input logic [REMW-1:0] rem,
                                              input logic nb,
                                              input logic [REMW-1:0] f);
      logic [REMW:0] t;
      logic [REMW:0] d;
      t = {rem, nb};
      d = t - {1'b0, f};
      if (t >= {1'b0, f}) begin
         return {1'b1, d[REMW-1:0]};
      end
      return {1'b0, t[REMW-1:0]};
   endfunction

   // clamp floor(p / 2^28) to just under 8.0
   function automatic logic [QB-1:0] clamp_q(input logic [SUMW-1:0] p);
      if (|p[SUMW-1:FRAC+QB]) begin
         return NMAX;
      end
      return p[FRAC+QB-1:FRAC];
   endfunction

   // valid bits shift with the payload
   logic [NST-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NST-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[NST-1];

   // zero focal length acts as one lsb, 1/16 pixel
   logic [REMW-1:0] fx_eff, fy_eff;
   assign fx_eff = (cfg.focal_x == '0) ? REMW'(1) : cfg.focal_x;
   assign fy_eff = (cfg.focal_y == '0) ? REMW'(1) : cfg.focal_y;

   // input register, masked to the used coordinate bits
   logic [USE_BITS-1:0] e0_x_ff, e0_y_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         e0_x_ff <= in_pixel_x[USE_BITS-1:0];
         e0_y_ff <= in_pixel_y[USE_BITS-1:0];
      end
   end

   // offset from principal point and its magnitude
   logic [SHW-1:0]        shx, shy;
   logic signed [DW-1:0]  dx_in, dy_in, ndx, ndy;
   logic [MW-1:0]         magx_in, magy_in;
   logic signed [DW-1:0]  e1_dx_ff, e1_dy_ff;
   logic [MW-1:0]         e1_magx_ff, e1_magy_ff;

   assign shx     = {e0_x_ff, {rud_pkg::PIX_FRAC{1'b0}}};
   assign shy     = {e0_y_ff, {rud_pkg::PIX_FRAC{1'b0}}};
   assign dx_in   = $signed(DW'(shx)) - $signed(DW'(cfg.centre_x));
   assign dy_in   = $signed(DW'(shy)) - $signed(DW'(cfg.centre_y));
   assign ndx     = $signed(DW'(cfg.centre_x)) - $signed(DW'(shx));
   assign ndy     = $signed(DW'(cfg.centre_y)) - $signed(DW'(shy));
   assign magx_in = dx_in[DW-1] ? ndx[MW-1:0] : dx_in[MW-1:0];
   assign magy_in = dy_in[DW-1] ? ndy[MW-1:0] : dy_in[MW-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_dx_ff   <= dx_in;
         e1_dy_ff   <= dy_in;
         e1_magx_ff <= magx_in;
         e1_magy_ff <= magy_in;
      end
   end

   // divider setup: overflow check and first partial remainder
   div_type div_ff [QB+1];
   div_type div_init;

   always_comb begin
      div_init.dx      = e1_dx_ff;
      div_init.dy      = e1_dy_ff;
      div_init.clamp_x = CMPW'(e1_magx_ff) >= CMPW'({fx_eff, {LOWB{1'b0}}});
      div_init.clamp_y = CMPW'(e1_magy_ff) >= CMPW'({fy_eff, {LOWB{1'b0}}});
      div_init.lo_x    = e1_magx_ff[LOWB-1:0];
      div_init.lo_y    = e1_magy_ff[LOWB-1:0];
      div_init.rem_x   = REMW'(e1_magx_ff >> LOWB);
      div_init.rem_y   = REMW'(e1_magy_ff >> LOWB);
      div_init.q_x     = '0;
      div_init.q_y     = '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         div_ff[0] <= div_init;
      end
   end

   // one quotient bit per stage, msb first
   for (genvar k = 0; k < QB; k++) begin : g_div
      localparam int J = QB - 1 - k;
      logic          nbx, nby;
      logic [REMW:0] sx, sy;
      div_type       nxt;

      if (J >= FRAC) begin : g_lo
         assign nbx = div_ff[k].lo_x[J-FRAC];
         assign nby = div_ff[k].lo_y[J-FRAC];
      end else begin : g_zero
         assign nbx = 1'b0;
         assign nby = 1'b0;
      end

      assign sx = div_step(div_ff[k].rem_x, nbx, fx_eff);
      assign sy = div_step(div_ff[k].rem_y, nby, fy_eff);

      always_comb begin
         nxt       = div_ff[k];
         nxt.rem_x = sx[REMW-1:0];
         nxt.rem_y = sy[REMW-1:0];
         nxt.q_x   = {div_ff[k].q_x[QB-2:0], sx[REMW]};
         nxt.q_y   = {div_ff[k].q_y[QB-2:0], sy[REMW]};
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[k+1] <= nxt;
         end
      end
   end

   // squares of the normalized magnitudes
   logic [QB-1:0]         ax, ay;
   logic [P2W-1:0]        m1_px2_ff, m1_py2_ff;
   logic signed [DW-1:0]  m1_dx_ff, m1_dy_ff;

   assign ax = div_ff[QB].clamp_x ? NMAX : div_ff[QB].q_x;
   assign ay = div_ff[QB].clamp_y ? NMAX : div_ff[QB].q_y;

   always_ff @(posedge clock) begin
      if (advance) begin
         m1_px2_ff <= ax * ax;
         m1_py2_ff <= ay * ay;
         m1_dx_ff  <= div_ff[QB].dx;
         m1_dy_ff  <= div_ff[QB].dy;
      end
   end

   // s2
   logic [SUMW-1:0]       sum2;
   logic [QB-1:0]         m2_s2_ff;
   logic signed [DW-1:0]  m2_dx_ff, m2_dy_ff;

   assign sum2 = SUMW'(m1_px2_ff) + SUMW'(m1_py2_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         m2_s2_ff <= clamp_q(sum2);
         m2_dx_ff <= m1_dx_ff;
         m2_dy_ff <= m1_dy_ff;
      end
   end

   // s2 squared and first term
   logic [P2W-1:0]        m3_p4_ff;
   logic signed [TW-1:0]  m3_t1_ff;
   logic [QB-1:0]         m3_s2_ff;
   logic signed [DW-1:0]  m3_dx_ff, m3_dy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m3_p4_ff <= m2_s2_ff * m2_s2_ff;
         m3_t1_ff <= $signed(cfg.coeff_one) * $signed({1'b0, m2_s2_ff});
         m3_s2_ff <= m2_s2_ff;
         m3_dx_ff <= m2_dx_ff;
         m3_dy_ff <= m2_dy_ff;
      end
   end

   // s4
   logic [QB-1:0]         m4_s4_ff, m4_s2_ff;
   logic signed [TW-1:0]  m4_t1_ff;
   logic signed [DW-1:0]  m4_dx_ff, m4_dy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m4_s4_ff <= clamp_q(SUMW'(m3_p4_ff));
         m4_s2_ff <= m3_s2_ff;
         m4_t1_ff <= m3_t1_ff;
         m4_dx_ff <= m3_dx_ff;
         m4_dy_ff <= m3_dy_ff;
      end
   end

   // s4 times s2 and second term
   logic [P2W-1:0]        m5_p6_ff;
   logic signed [TW-1:0]  m5_t1_ff, m5_t2_ff;
   logic signed [DW-1:0]  m5_dx_ff, m5_dy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m5_p6_ff <= m4_s4_ff * m4_s2_ff;
         m5_t2_ff <= $signed(cfg.coeff_two) * $signed({1'b0, m4_s4_ff});
         m5_t1_ff <= m4_t1_ff;
         m5_dx_ff <= m4_dx_ff;
         m5_dy_ff <= m4_dy_ff;
      end
   end

   // s6
   logic [QB-1:0]         m6_s6_ff;
   logic signed [TW-1:0]  m6_t1_ff, m6_t2_ff;
   logic signed [DW-1:0]  m6_dx_ff, m6_dy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m6_s6_ff <= clamp_q(SUMW'(m5_p6_ff));
         m6_t1_ff <= m5_t1_ff;
         m6_t2_ff <= m5_t2_ff;
         m6_dx_ff <= m5_dx_ff;
         m6_dy_ff <= m5_dy_ff;
      end
   end

   // third term
   logic signed [TW-1:0]  m7_t1_ff, m7_t2_ff, m7_t3_ff;
   logic signed [DW-1:0]  m7_dx_ff, m7_dy_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         m7_t3_ff <= $signed(cfg.coeff_three) * $signed({1'b0, m6_s6_ff});
         m7_t1_ff <= m6_t1_ff;
         m7_t2_ff <= m6_t2_ff;
         m7_dx_ff <= m6_dx_ff;
         m7_dy_ff <= m6_dy_ff;
      end
   end

   // scale factor, each term floored on its own
   logic signed [FW-1:0]  factor_in, m8_f_ff;
   logic signed [DW-1:0]  m8_dx_ff, m8_dy_ff;

   assign factor_in = FACTOR_ONE + FW'(m7_t1_ff >>> FRAC) + FW'(m7_t2_ff >>> FRAC)
                    + FW'(m7_t3_ff >>> FRAC);

   always_ff @(posedge clock) begin
      if (advance) begin
         m8_f_ff  <= factor_in;
         m8_dx_ff <= m7_dx_ff;
         m8_dy_ff <= m7_dy_ff;
      end
   end

   // offset times factor, split into high and low partial products
   logic signed [FHW-1:0] fhi;
   logic [FLW-1:0]        flo;
   logic signed [PHW-1:0] m9_phx_ff, m9_phy_ff;
   logic signed [PLW-1:0] m9_plx_ff, m9_ply_ff;

   assign fhi = $signed(m8_f_ff[FW-1:FLW]);
   assign flo = m8_f_ff[FLW-1:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         m9_phx_ff <= m8_dx_ff * fhi;
         m9_phy_ff <= m8_dy_ff * fhi;
         m9_plx_ff <= m8_dx_ff * $signed({1'b0, flo});
         m9_ply_ff <= m8_dy_ff * $signed({1'b0, flo});
      end
   end

   // combine partial products and floor back to 4 fraction bits
   logic signed [PW-1:0] prodx, prody;
   logic signed [VW-1:0] m10_vx_ff, m10_vy_ff;

   assign prodx = (PW'(m9_phx_ff) <<< FLW) + PW'(m9_plx_ff);
   assign prody = (PW'(m9_phy_ff) <<< FLW) + PW'(m9_ply_ff);

   always_ff @(posedge clock) begin
      if (advance) begin
         m10_vx_ff <= prodx[PW-1:FRAC];
         m10_vy_ff <= prody[PW-1:FRAC];
      end
   end

   // add the principal point back and saturate
   logic signed [SW-1:0] vx, vy;
   logic                 hix, lox, hiy, loy;
   rud_pkg::rsp_type     rsp_in, m11_rsp_ff;

   assign vx  = SW'(m10_vx_ff) + $signed(SW'(cfg.centre_x));
   assign vy  = SW'(m10_vy_ff) + $signed(SW'(cfg.centre_y));
   assign hix = vx > SAT_HI;
   assign lox = vx < SAT_LO;
   assign hiy = vy > SAT_HI;
   assign loy = vy < SAT_LO;

   always_comb begin
      rsp_in.corrected_x = hix ? SAT_HI[rud_pkg::OUT_BITS-1:0]
                         : (lox ? SAT_LO[rud_pkg::OUT_BITS-1:0] : vx[rud_pkg::OUT_BITS-1:0]);
      rsp_in.corrected_y = hiy ? SAT_HI[rud_pkg::OUT_BITS-1:0]
                         : (loy ? SAT_LO[rud_pkg::OUT_BITS-1:0] : vy[rud_pkg::OUT_BITS-1:0]);
      rsp_in.saturated   = hix | lox | hiy | loy;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m11_rsp_ff <= rsp_in;
      end
   end

   assign out_rsp = m11_rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/radial_undistort_pixel.sv =====
// radial_undistort_pixel: top level with register port, stream handshakes and
// output skid stage around the pipelined datapath
// depends on rud_pkg and rud_core
//
// Usage: write the principal point, focal lengths and the three polynomial
// coefficients over the register port (byte address 4 * index) while the
// block is idle, then stream pixel coordinates into the req_ channel. Each
// accepted beat produces exactly one corrected coordinate beat on the rsp_
// channel, in order; tuser carries the saturation flag.
// Throughput is one beat per cycle while req_tready stays high. An
// accepted beat loads the first of 46 register stages, which are 3 setup
// stages, 31 stages of the bit-per-stage restoring divider for the
// normalized coordinate, 11 stages of multiplies, polynomial sum, rescale
// and saturation, and the output register.
// When the receiver stalls, the output register holds its beat and one
// further beat lands in a skid register; only then does req_tready drop and
// the whole pipeline freeze, so no beat is lost or repeated.
// Synchronous reset empties the pipeline and sets the registers to their
// defaults: centres 0, focal lengths 1.0 pixel, coefficients 0.
`timescale 1ns / 1ps
`default_nettype none

module radial_undistort_pixel #(
   parameter int COORD_BITS = 12
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // input stream
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [rud_pkg::REQ_DATA_BITS-1:0]     req_tdata,   // pixel_x, pixel_y
   // result stream
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [rud_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,   // corrected_x, corrected_y
   output logic [rud_pkg::RSP_USER_BITS-1:0]    rsp_tuser,   // saturated
   // register port
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire [rud_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire [rud_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [rud_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int PB = rud_pkg::PIXEL_BITS;
   localparam int OB = rud_pkg::OUT_BITS;

   // configuration registers
   rud_pkg::cfg_type                   cfg_ff;
   logic [rud_pkg::REG_IDX_BITS-1:0]   csr_idx;
   logic                               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[rud_pkg::CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.centre_x    <= '0;
         cfg_ff.centre_y    <= '0;
         cfg_ff.focal_x     <= rud_pkg::FOCAL_RESET;
         cfg_ff.focal_y     <= rud_pkg::FOCAL_RESET;
         cfg_ff.coeff_one   <= '0;
         cfg_ff.coeff_two   <= '0;
         cfg_ff.coeff_three <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            rud_pkg::REG_CENTRE_X: begin
               cfg_ff.centre_x <= csr_pwdata[rud_pkg::CENTRE_BITS-1:0];
            end
            rud_pkg::REG_CENTRE_Y: begin
               cfg_ff.centre_y <= csr_pwdata[rud_pkg::CENTRE_BITS-1:0];
            end
            rud_pkg::REG_FOCAL_X: begin
               cfg_ff.focal_x <= csr_pwdata[rud_pkg::FOCAL_BITS-1:0];
            end
            rud_pkg::REG_FOCAL_Y: begin
               cfg_ff.focal_y <= csr_pwdata[rud_pkg::FOCAL_BITS-1:0];
            end
            rud_pkg::REG_COEFF_ONE: begin
               cfg_ff.coeff_one <= csr_pwdata[rud_pkg::COEFF_BITS-1:0];
            end
            rud_pkg::REG_COEFF_TWO: begin
               cfg_ff.coeff_two <= csr_pwdata[rud_pkg::COEFF_BITS-1:0];
            end
            rud_pkg::REG_COEFF_THREE: begin
               cfg_ff.coeff_three <= csr_pwdata[rud_pkg::COEFF_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (csr_idx)
         rud_pkg::REG_CENTRE_X:    csr_prdata = rud_pkg::CSR_DATA_BITS'(cfg_ff.centre_x);
         rud_pkg::REG_CENTRE_Y:    csr_prdata = rud_pkg::CSR_DATA_BITS'(cfg_ff.centre_y);
         rud_pkg::REG_FOCAL_X:     csr_prdata = rud_pkg::CSR_DATA_BITS'(cfg_ff.focal_x);
         rud_pkg::REG_FOCAL_Y:     csr_prdata = rud_pkg::CSR_DATA_BITS'(cfg_ff.focal_y);
         rud_pkg::REG_COEFF_ONE:   csr_prdata = cfg_ff.coeff_one;
         rud_pkg::REG_COEFF_TWO:   csr_prdata = cfg_ff.coeff_two;
         rud_pkg::REG_COEFF_THREE: csr_prdata = cfg_ff.coeff_three;
         default:                  csr_prdata = '0;
      endcase
   end

   // pipeline moves whenever the skid register is free
   logic             advance;
   logic             core_valid;
   rud_pkg::rsp_type core_rsp;
   logic             rsp_valid_ff, skid_valid_ff;

   assign advance    = ~skid_valid_ff;
   assign req_tready = advance;

   rud_core #(
      .COORD_BITS (COORD_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_pixel_x (req_tdata[PB-1:0]),
      .in_pixel_y (req_tdata[2*PB-1:PB]),
      .cfg        (cfg_ff),
      .out_valid  (core_valid),
      .out_rsp    (core_rsp)
   );

   // output register plus skid register
   rud_pkg::rsp_type rsp_ff, skid_ff;
   logic             take;
   logic             out_free;

   assign take     = core_valid & advance;
   assign out_free = ~rsp_valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= take;
         end
      end else if (take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_ff <= skid_valid_ff ? skid_ff : core_rsp;
      end else if (take) begin
         skid_ff <= core_rsp;
      end
   end

   // result beat packing
   assign rsp_tvalid            = rsp_valid_ff;
   assign rsp_tdata[OB-1:0]     = rsp_ff.corrected_x;
   assign rsp_tdata[2*OB-1:OB]  = rsp_ff.corrected_y;
   assign rsp_tuser[0]          = rsp_ff.saturated;

endmodule

`default_nettype wire
